>>> rtl/kipd_pkg.sv
// Package for the KNXnet/IP frame deframer: item and result types,
// status codes and header constants. No dependencies.
package kipd_pkg;

  localparam logic [15:0] HDR_SIZE      = 16'd6;
  localparam logic [7:0]  PROTO_VERSION = 8'h10;
  localparam logic [15:0] MAX_LEN_RESET = 16'd512;

  typedef enum logic [2:0] {
    ST_IN_FRAME   = 3'd0,
    ST_COMPLETE   = 3'd1,
    ST_MALFORMED  = 3'd2,
    ST_BAD_LENGTH = 3'd3,
    ST_REJECTED   = 3'd4,
    ST_CLEARED    = 3'd5
  } status_t;

  typedef enum logic {
    FUNC_PUSH  = 1'b0,
    FUNC_CLEAR = 1'b1
  } func_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] offset;
    status_t     status;
    logic [15:0] length;
  } result_t;

endpackage

>>> rtl/knxnet_ip_frame_deframer.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------------
// input    | in_valid / in_stall   | func, data_in
// output   | out_valid / out_stall | data_out, byte_offset, status, frame_length
// config   | cfg_valid / cfg_ready | max_frame_length
//
// One beat is accepted per cycle while in_stall is low.
// The input register and the result register decouple the two sides, so a
// new beat is taken while a finished result waits. rst is synchronous and
// clears framing state, the fault and sets max_frame_length to 512. A stall on
// the output stalls the input only once both registers are full.
// Top level of the KNXnet/IP frame deframer; uses kipd_pkg, kipd_in_stage,
// kipd_frame_core and kipd_out_stage.
module knxnet_ip_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  data_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_out,
  output logic [15:0] byte_offset,
  output logic [2:0]  status,
  output logic [15:0] frame_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] max_frame_length
);
  import kipd_pkg::*;

  item_t   in_item;
  item_t   item;
  result_t result;
  result_t out_result;
  logic    take;
  logic    fire;

  assign in_item.func = func_t'(func);
  assign in_item.data = data_in;
  assign cfg_ready    = 1'b1;

  kipd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (take),
    .fire     (fire),
    .item     (item)
  );

  kipd_frame_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (max_frame_length),
    .fire     (fire),
    .item     (item),
    .result   (result)
  );

  kipd_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .result     (result),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign data_out     = out_result.data;
  assign byte_offset  = out_result.offset;
  assign status       = out_result.status;
  assign frame_length = out_result.length;

endmodule

>>> rtl/kipd_in_stage.sv
// Input register of the deframer: holds one accepted beat until the
// result stage can take it. Depends on kipd_pkg.
module kipd_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  kipd_pkg::item_t in_item,
  input  logic            take,
  output logic            fire,
  output kipd_pkg::item_t item
);
  import kipd_pkg::*;

  logic held;

  assign fire     = held & take;
  assign in_stall = held & ~take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held <= 1'b1;
    end else if (fire) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_item;
    end
  end

endmodule

>>> rtl/kipd_frame_core.sv
// Framing state, header checks and result formation for one beat.
// Depends on kipd_pkg.
module kipd_frame_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data,
  input  logic              fire,
  input  kipd_pkg::item_t   item,
  output kipd_pkg::result_t result
);
  import kipd_pkg::*;

  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_MALFORMED = 2'd1,
    FAULT_LENGTH    = 2'd2
  } fault_t;

  logic [15:0] max_len;
  logic [15:0] position, position_next;
  logic [7:0]  hdr_size, hdr_size_next;
  logic [7:0]  version, version_next;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] total_length, total_length_next;
  fault_t      fault, fault_next;

  logic [15:0] total;
  logic        bad;
  logic [16:0] off_inc;

  assign total   = {length_high, item.data};
  assign bad     = (hdr_size != HDR_SIZE[7:0]) || (version != PROTO_VERSION) ||
                   (total < HDR_SIZE);
  assign off_inc = {1'b0, position} + 17'd1;

  always_comb begin
    position_next     = position;
    hdr_size_next     = hdr_size;
    version_next      = version;
    length_high_next  = length_high;
    total_length_next = total_length;
    fault_next        = fault;
    result.data       = item.data;
    result.offset     = position;
    result.status     = ST_IN_FRAME;
    result.length     = 16'd0;

    if (item.func == FUNC_CLEAR) begin
      position_next     = 16'd0;
      hdr_size_next     = 8'd0;
      version_next      = 8'd0;
      length_high_next  = 8'd0;
      total_length_next = 16'd0;
      fault_next        = FAULT_NONE;
      result.data       = 8'd0;
      result.offset     = 16'd0;
      result.status     = ST_CLEARED;
    end else if (fault != FAULT_NONE) begin
      result.offset = 16'd0;
      result.status = ST_REJECTED;
    end else if (position < HDR_SIZE - 16'd1) begin
      if (position == 16'd0) hdr_size_next = item.data;
      else if (position == 16'd1) version_next = item.data;
      else if (position == 16'd4) length_high_next = item.data;
      position_next = off_inc[15:0];
    end else if (position == HDR_SIZE - 16'd1) begin
      result.length = total;
      if (bad || total > max_len) begin
        fault_next        = bad ? FAULT_MALFORMED : FAULT_LENGTH;
        position_next     = 16'd0;
        total_length_next = 16'd0;
        result.status     = bad ? ST_MALFORMED : ST_BAD_LENGTH;
      end else if (total == HDR_SIZE) begin
        position_next     = 16'd0;
        total_length_next = 16'd0;
        result.status     = ST_COMPLETE;
      end else begin
        total_length_next = total;
        position_next     = HDR_SIZE;
      end
    end else begin
      // Payload beat: the frame ends once the next offset reaches the total.
      result.length = total_length;
      if (off_inc >= {1'b0, total_length}) begin
        position_next     = 16'd0;
        total_length_next = 16'd0;
        result.status     = ST_COMPLETE;
      end else begin
        position_next = off_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len      <= MAX_LEN_RESET;
      position     <= 16'd0;
      hdr_size     <= 8'd0;
      version      <= 8'd0;
      length_high  <= 8'd0;
      total_length <= 16'd0;
      fault        <= FAULT_NONE;
    end else begin
      if (cfg_we) begin
        max_len <= cfg_data;
      end
      if (fire) begin
        position     <= position_next;
        hdr_size     <= hdr_size_next;
        version      <= version_next;
        length_high  <= length_high_next;
        total_length <= total_length_next;
        fault        <= fault_next;
      end
    end
  end

  // A latched fault always leaves the framing position at the frame start.
  a_fault_pos: assert property (@(posedge clk) disable iff (rst)
    (fault != FAULT_NONE) |-> (position == 16'd0))
    else $error("fault latched with nonzero position");

  // The frame length is known exactly while the position is past the header.
  a_len_known: assert property (@(posedge clk) disable iff (rst)
    (position < HDR_SIZE) == (total_length == 16'd0))
    else $error("frame length and position disagree");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (position >= HDR_SIZE) |-> (position < total_length))
    else $error("position ran past the frame length");

  // A clear beat leaves no fault behind.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (fire && item.func == FUNC_CLEAR) |=> (fault == FAULT_NONE && position == 16'd0))
    else $error("clear did not reset framing state");

endmodule

>>> rtl/kipd_out_stage.sv
// Result register of the deframer, held while the receiver stalls.
// Depends on kipd_pkg.
module kipd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  kipd_pkg::result_t result,
  output logic              take,
  output logic              out_valid,
  input  logic              out_stall,
  output kipd_pkg::result_t out_result
);
  import kipd_pkg::*;

  assign take = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= result;
    end
  end

endmodule

>>> sim/tb.sv
// Self-checking testbench for knxnet_ip_frame_deframer: directed header cases, then random
// well-formed, broken and noisy frame streams under several length limits, scored against a
// local predictor or a typed expectation. Depends on kipd_pkg and the deframer RTL only.
module tb;
  import kipd_pkg::*;

  typedef enum logic [1:0] {NO_FAULT, FAULT_MALFORMED, FAULT_LENGTH} fault_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  func_t       op = FUNC_PUSH;
  logic [7:0]  data_in = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  data_out;
  logic [15:0] byte_offset;
  logic [2:0]  status;
  logic [15:0] frame_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] max_frame_length = 16'd0;

  knxnet_ip_frame_deframer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .func(op), .data_in(data_in),
    .out_valid(out_valid), .out_stall(out_stall), .data_out(data_out),
    .byte_offset(byte_offset), .status(status), .frame_length(frame_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .max_frame_length(max_frame_length)
  );

  always #5 clk = ~clk;

  initial begin
    #3000000;
    $display("[knxnet_ip_frame_deframer] ERROR");
    $finish;
  end

  // Predictor state, mirroring the deframer after reset.
  logic [15:0] frame_limit = MAX_LEN_RESET;
  logic [15:0] frm_pos     = 16'd0;
  logic [7:0]  hdr_size    = 8'd0;
  logic [7:0]  hdr_version = 8'd0;
  logic [7:0]  len_hi      = 8'd0;
  logic [15:0] frm_total   = 16'd0;
  fault_t      fault_kind  = NO_FAULT;

  result_t pending_results[$];
  int beats_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int frames_done = 0;
  int header_faults = 0;
  int bytes_rejected = 0;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int stall_left = 0;
  bit quiet_tail = 1'b0;

  // Directed stimulus table.
  func_t       dir_func[$];
  logic [7:0]  dir_byte[$];
  bit          dir_typed[$];
  result_t     dir_want[$];

  function automatic result_t res(logic [7:0] d, logic [15:0] off, status_t st,
                                  logic [15:0] len);
    result_t r;
    r.data = d;
    r.offset = off;
    r.status = st;
    r.length = len;
    return r;
  endfunction

  function automatic result_t deframe_byte(func_t f, logic [7:0] b);
    logic [15:0] total;
    logic [15:0] off;
    bit malformed;
    if (f == FUNC_CLEAR) begin
      frm_pos = '0;
      hdr_size = '0;
      hdr_version = '0;
      len_hi = '0;
      frm_total = '0;
      fault_kind = NO_FAULT;
      return res(8'h00, 16'd0, ST_CLEARED, 16'd0);
    end
    if (fault_kind != NO_FAULT)
      return res(b, 16'd0, ST_REJECTED, 16'd0);
    off = frm_pos;
    if (off < HDR_SIZE - 16'd1) begin
      if (off == 16'd0) hdr_size = b;
      else if (off == 16'd1) hdr_version = b;
      else if (off == 16'd4) len_hi = b;
      frm_pos = off + 16'd1;
      return res(b, off, ST_IN_FRAME, 16'd0);
    end
    if (off == HDR_SIZE - 16'd1) begin
      total = {len_hi, b};
      malformed = ({8'h00, hdr_size} != HDR_SIZE) || (hdr_version != PROTO_VERSION) ||
                  (total < HDR_SIZE);
      if (malformed || total > frame_limit) begin
        fault_kind = malformed ? FAULT_MALFORMED : FAULT_LENGTH;
        frm_pos = '0;
        frm_total = '0;
        return res(b, off, malformed ? ST_MALFORMED : ST_BAD_LENGTH, total);
      end
      if (total == HDR_SIZE) begin
        frm_pos = '0;
        frm_total = '0;
        return res(b, off, ST_COMPLETE, total);
      end
      frm_total = total;
      frm_pos = HDR_SIZE;
      return res(b, off, ST_IN_FRAME, total);
    end
    total = frm_total;
    if ({1'b0, off} + 17'd1 >= {1'b0, total}) begin
      frm_pos = '0;
      frm_total = '0;
      return res(b, off, ST_COMPLETE, total);
    end
    frm_pos = off + 16'd1;
    return res(b, off, ST_IN_FRAME, total);
  endfunction

  task automatic add_row(func_t f, logic [7:0] b, bit typed = 1'b0, result_t want = '0);
    dir_func.push_back(f);
    dir_byte.push_back(b);
    dir_typed.push_back(typed);
    dir_want.push_back(want);
  endtask

  // Drives one beat and holds it until taken; the expectation is queued on acceptance.
  task automatic send_beat(func_t f, logic [7:0] b, bit use_typed = 1'b0,
                           result_t typed = '0);
    result_t predicted;
    in_valid <= 1'b1;
    op <= f;
    data_in <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = deframe_byte(f, b);
    pending_results.push_back(use_typed ? typed : predicted);
    beats_sent++;
    if (!quiet_tail && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    max_frame_length <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    frame_limit = v;
  endtask

  task automatic send_header(logic [7:0] size, logic [7:0] ver, logic [15:0] total);
    send_beat(FUNC_PUSH, size);
    send_beat(FUNC_PUSH, ver);
    send_beat(FUNC_PUSH, 8'($urandom_range(0, 255)));
    send_beat(FUNC_PUSH, 8'($urandom_range(0, 255)));
    send_beat(FUNC_PUSH, total[15:8]);
    send_beat(FUNC_PUSH, total[7:0]);
  endtask

  task automatic send_good_frame();
    int cap;
    int total;
    int stop;
    cap = (frame_limit < 16'd200) ? int'(frame_limit) : 200;
    if (cap < 6) cap = 6;
    total = ($urandom_range(0, 15) == 0) ? $urandom_range(6, cap)
                                         : $urandom_range(6, (cap < 30) ? cap : 30);
    // Now and then the frame is cut short and the next clear resynchronises.
    stop = ($urandom_range(0, 9) == 0) ? $urandom_range(6, total) : total;
    send_header(8'h06, PROTO_VERSION, total[15:0]);
    for (int k = 6; k < stop; k++)
      send_beat(FUNC_PUSH, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_bad_header();
    logic [7:0]  size;
    logic [7:0]  ver;
    logic [15:0] total;
    size = 8'h06;
    ver = PROTO_VERSION;
    total = 16'($urandom_range(6, 40));
    case ($urandom_range(0, 3))
      0: begin
        size = 8'($urandom_range(0, 254));
        if (size >= 8'h06) size = size + 8'd1;
      end
      1: begin
        ver = 8'($urandom_range(0, 254));
        if (ver >= PROTO_VERSION) ver = ver + 8'd1;
      end
      2: total = 16'($urandom_range(0, 5));
      default: begin
        if (frame_limit == 16'hFFFF) total = 16'($urandom_range(0, 5));
        else total = 16'($urandom_range(int'(frame_limit) + 1, 65535));
      end
    endcase
    if ($urandom_range(0, 3) == 0) total = 16'($urandom_range(0, 65535));
    send_header(size, ver, total);
    repeat ($urandom_range(0, 3)) send_beat(FUNC_PUSH, 8'($urandom_range(0, 255)));
  endtask

  task automatic run_phase(logic [15:0] v, int n);
    int stop_at;
    int drain_at;
    int pick;
    bit paused;
    bit resync;
    paused = 1'b0;
    write_limit(v);
    stop_at = beats_sent + n;
    drain_at = beats_sent + n / 2;
    while (beats_sent < stop_at) begin
      if (quiet_tail) begin
        tx_gap_pct = 0;
        rx_stall_pct = 0;
      end else begin
        tx_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 12;
        rx_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 15;
      end
      // Hold the sender back once per phase until every result is in.
      if (!paused && beats_sent >= drain_at) begin
        wait_drained();
        paused = 1'b1;
      end
      if (fault_kind != NO_FAULT) resync = ($urandom_range(0, 9) < 8);
      else resync = (frm_pos != 16'd0) && ($urandom_range(0, 9) < 9);
      if (resync) send_beat(FUNC_CLEAR, 8'($urandom_range(0, 255)));
      pick = $urandom_range(0, 99);
      if (pick < 60) send_good_frame();
      else if (pick < 85) send_bad_header();
      else if (pick < 94)
        repeat ($urandom_range(1, 6)) send_beat(FUNC_PUSH, 8'($urandom_range(0, 255)));
      else send_beat(FUNC_CLEAR, 8'($urandom_range(0, 255)));
    end
  endtask

  function automatic void flag_mismatch(string field, int want, int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s of result %0d: expected %0h, got %0h",
               field, results_checked, want, got);
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet_tail && $urandom_range(0, 99) < rx_stall_pct) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : watch_results
    result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (status == ST_COMPLETE) frames_done++;
      if (status == ST_MALFORMED || status == ST_BAD_LENGTH) header_faults++;
      if (status == ST_REJECTED) bytes_rejected++;
      if (pending_results.size() == 0) begin
        flag_mismatch("presence (nothing pending)", 0, 1);
      end else begin
        want = pending_results.pop_front();
        if (data_out !== want.data) flag_mismatch("data_out", want.data, data_out);
        if (byte_offset !== want.offset)
          flag_mismatch("byte_offset", want.offset, byte_offset);
        if (status !== want.status) flag_mismatch("status", want.status, status);
        if (frame_length !== want.length)
          flag_mismatch("frame_length", want.length, frame_length);
      end
      results_checked++;
    end
  end

  initial begin
    // Clear first, then a header-only frame, a seven-byte frame, an oversized total
    // followed by a rejected byte and a clear, and a bad header size carrying a total
    // that is also too long, which must still be reported as malformed.
    add_row(FUNC_CLEAR, 8'hA5, 1'b1, res(8'h00, 16'd0, ST_CLEARED, 16'd0));
    add_row(FUNC_PUSH, 8'h06, 1'b1, res(8'h06, 16'd0, ST_IN_FRAME, 16'd0));
    add_row(FUNC_PUSH, 8'h10);
    add_row(FUNC_PUSH, 8'h02);
    add_row(FUNC_PUSH, 8'h05);
    add_row(FUNC_PUSH, 8'h00);
    add_row(FUNC_PUSH, 8'h06, 1'b1, res(8'h06, 16'd5, ST_COMPLETE, 16'd6));
    add_row(FUNC_PUSH, 8'h06);
    add_row(FUNC_PUSH, 8'h10);
    add_row(FUNC_PUSH, 8'h04);
    add_row(FUNC_PUSH, 8'h20);
    add_row(FUNC_PUSH, 8'h00);
    add_row(FUNC_PUSH, 8'h07);
    add_row(FUNC_PUSH, 8'hFF, 1'b1, res(8'hFF, 16'd6, ST_COMPLETE, 16'd7));
    add_row(FUNC_PUSH, 8'h06);
    add_row(FUNC_PUSH, 8'h10);
    add_row(FUNC_PUSH, 8'h04);
    add_row(FUNC_PUSH, 8'h20);
    add_row(FUNC_PUSH, 8'hFF);
    add_row(FUNC_PUSH, 8'hFF, 1'b1, res(8'hFF, 16'd5, ST_BAD_LENGTH, 16'hFFFF));
    add_row(FUNC_PUSH, 8'h00, 1'b1, res(8'h00, 16'd0, ST_REJECTED, 16'd0));
    add_row(FUNC_CLEAR, 8'hFF, 1'b1, res(8'h00, 16'd0, ST_CLEARED, 16'd0));
    add_row(FUNC_PUSH, 8'h07);
    add_row(FUNC_PUSH, 8'h10);
    add_row(FUNC_PUSH, 8'h04);
    add_row(FUNC_PUSH, 8'h20);
    add_row(FUNC_PUSH, 8'hFF);
    add_row(FUNC_PUSH, 8'hFF, 1'b1, res(8'hFF, 16'd5, ST_MALFORMED, 16'hFFFF));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // The table runs at the reset limit of 512 bytes.
    for (int i = 0; i < dir_byte.size(); i++)
      send_beat(dir_func[i], dir_byte[i], dir_typed[i], dir_want[i]);

    run_phase(16'd6, 220);
    run_phase(16'hFFFF, 220);
    run_phase(16'd0, 220);
    run_phase(16'd5, 150);
    run_phase(16'($urandom_range(6, 65535)), 220);
    run_phase(16'd100, 220);
    quiet_tail = 1'b1;
    run_phase(MAX_LEN_RESET, 250);

    wait_drained();
    repeat (10) @(posedge clk);

    $display("Sent %0d beats under seven length limits from 0 to 65535; %0d results checked.",
             beats_sent, results_checked);
    $display("Seen: %0d frames completed, %0d header faults, %0d bytes rejected, %0d mismatches.",
             frames_done, header_faults, bytes_rejected, mismatches);
    if (mismatches == 0)
      $display("[knxnet_ip_frame_deframer] OK");
    else
      $display("[knxnet_ip_frame_deframer] ERROR");
    $finish;
  end

endmodule
